@@ sv/tsm_pkg.sv @@
// ----------------------------------------------------------------------------
// tsm_pkg: shared types and constants of the touch sample mapper
// burst length, datapath widths, register codes and the queued burst record
// ----------------------------------------------------------------------------
`default_nettype none

package tsm_pkg;

  // burst and sample geometry
  localparam int unsigned BURST_SAMPLES = 16;
  localparam int unsigned DATA_W        = 12;
  localparam int unsigned CNT_W         = $clog2(BURST_SAMPLES);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BURST_SAMPLES - 1);
  localparam int unsigned SUM_W         = DATA_W + CNT_W;
  localparam int unsigned LO_W          = 16;
  localparam logic [LO_W-1:0] LO_RESET  = 16'h8000;
  localparam int unsigned EXT_W         = LO_W + 2;
  localparam logic [DATA_W-1:0] PRESSURE_MIN = 12'd300;

  // trimmed mean divide by a constant through a reciprocal multiply
  localparam int unsigned MEAN_DIV    = BURST_SAMPLES - 4;
  localparam int unsigned RECIP_SHIFT = SUM_W;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((64'd1 << RECIP_SHIFT) / MEAN_DIV);
  localparam logic [SUM_W-1:0] MEAN_DIV_V = SUM_W'(MEAN_DIV);
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;

  // ratio divider, two quotient bits per cycle
  localparam int unsigned DIV_W      = DATA_W;
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_CYCLES = DIV_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

  // signed screen coordinates before clamping
  localparam int unsigned POS_W = DATA_W + 2;

  // burst queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CALIBRATE = 3'd0,
    CFG_OFFSET_X  = 3'd1,
    CFG_OFFSET_Y  = 3'd2,
    CFG_RATIO_X   = 3'd3,
    CFG_RATIO_Y   = 3'd4,
    CFG_SCREEN_W  = 3'd5,
    CFG_SCREEN_H  = 3'd6,
    CFG_ROTATION  = 3'd7
  } tsm_cfg_idx_e;

  typedef enum logic [1:0] {
    ROT_PORTRAIT_0    = 2'd0,
    ROT_LANDSCAPE_90  = 2'd1,
    ROT_PORTRAIT_180  = 2'd2,
    ROT_LANDSCAPE_270 = 2'd3
  } tsm_rot_e;

  typedef struct packed {
    logic              calibrate;
    logic [DATA_W-1:0] offset_x;
    logic [DATA_W-1:0] offset_y;
    logic [DATA_W-1:0] ratio_x;
    logic [DATA_W-1:0] ratio_y;
    logic [DATA_W-1:0] screen_w;
    logic [DATA_W-1:0] screen_h;
    tsm_rot_e          rotation;
  } tsm_cfg_t;

  localparam tsm_cfg_t CFG_RESET = '{
    calibrate: 1'b0,
    offset_x:  12'd0,
    offset_y:  12'd0,
    ratio_x:   12'd1,
    ratio_y:   12'd1,
    screen_w:  12'd320,
    screen_h:  12'd240,
    rotation:  ROT_LANDSCAPE_270
  };

  typedef logic [1:0][LO_W-1:0]   tsm_lo_pair_t;
  typedef logic [1:0][DATA_W-1:0] tsm_hi_pair_t;

  // one finished burst: sums and extremes, index 0 is the most extreme
  typedef struct packed {
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    tsm_lo_pair_t     lo_x;
    tsm_lo_pair_t     lo_y;
    tsm_hi_pair_t     hi_x;
    tsm_hi_pair_t     hi_y;
  } tsm_burst_t;

endpackage

`default_nettype wire

@@ sv/tsm_if.sv @@
// ----------------------------------------------------------------------------
// tsm_if: valid/ready channels of the touch sample mapper
// sample channel in, touch point channel out
// ----------------------------------------------------------------------------
`default_nettype none

interface tsm_sample_if;
  import tsm_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sample_pressure;
  logic [DATA_W-1:0] sample_x;
  logic [DATA_W-1:0] sample_y;

  modport source (output valid, output sample_pressure, output sample_x,
                  output sample_y, input ready);
  modport sink   (input valid, input sample_pressure, input sample_x,
                  input sample_y, output ready);
endinterface

interface tsm_touch_if;
  import tsm_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] touch_x;
  logic [DATA_W-1:0] touch_y;

  modport source (output valid, output touch_x, output touch_y, input ready);
  modport sink   (input valid, input touch_x, input touch_y, output ready);
endinterface

`default_nettype wire

@@ sv/tsm_front.sv @@
// ----------------------------------------------------------------------------
// tsm_front: burst accumulator
// sums each axis, tracks the two lowest and highest values, flags low pressure
// ----------------------------------------------------------------------------
`default_nettype none

module tsm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  tsm_sample_if.sink          sample_i,
  output logic                push_o,
  output tsm_pkg::tsm_burst_t entry_o,
  input  logic                space_i
);
  import tsm_pkg::*;

  localparam tsm_burst_t ACC_CLEAR = '{
    sum_x: '0,
    sum_y: '0,
    lo_x:  {2{LO_RESET}},
    lo_y:  {2{LO_RESET}},
    hi_x:  '0,
    hi_y:  '0
  };

  tsm_burst_t       acc_q, acc_d, upd;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             bad_q, bad_d;
  logic             accept, last, good;

  function automatic tsm_lo_pair_t track_lo(input logic [DATA_W-1:0] v,
                                            input tsm_lo_pair_t lo);
    tsm_lo_pair_t    r;
    logic [LO_W-1:0] vw;
    vw = LO_W'(v);
    r  = lo;
    if (vw < lo[0]) begin
      r[1] = lo[0];
      r[0] = vw;
    end else if (vw < lo[1]) begin
      r[1] = vw;
    end
    return r;
  endfunction

  function automatic tsm_hi_pair_t track_hi(input logic [DATA_W-1:0] v,
                                            input tsm_hi_pair_t hi);
    tsm_hi_pair_t r;
    r = hi;
    if (v > hi[0]) begin
      r[1] = hi[0];
      r[0] = v;
    end else if (v > hi[1]) begin
      r[1] = v;
    end
    return r;
  endfunction

  // stall only when the closing beat of a burst finds the queue full
  assign last           = (cnt_q == LAST_CNT);
  assign sample_i.ready = !last || space_i;
  assign accept         = sample_i.valid && sample_i.ready;
  assign good           = (sample_i.sample_pressure > PRESSURE_MIN);

  // accumulator update for a good sample
  always_comb begin
    upd = acc_q;
    if (good) begin
      upd.sum_x = acc_q.sum_x + SUM_W'(sample_i.sample_x);
      upd.sum_y = acc_q.sum_y + SUM_W'(sample_i.sample_y);
      upd.lo_x  = track_lo(sample_i.sample_x, acc_q.lo_x);
      upd.lo_y  = track_lo(sample_i.sample_y, acc_q.lo_y);
      upd.hi_x  = track_hi(sample_i.sample_x, acc_q.hi_x);
      upd.hi_y  = track_hi(sample_i.sample_y, acc_q.hi_y);
    end
  end

  // burst bookkeeping, clear after the closing beat
  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    bad_d = bad_q;
    if (accept) begin
      if (last) begin
        acc_d = ACC_CLEAR;
        cnt_d = '0;
        bad_d = 1'b0;
      end else begin
        acc_d = upd;
        cnt_d = cnt_q + 1'b1;
        bad_d = bad_q | !good;
      end
    end
  end

  assign push_o  = accept && last && good && !bad_q;
  assign entry_o = upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= ACC_CLEAR;
      cnt_q <= '0;
      bad_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      bad_q <= bad_d;
    end
  end

  // a stall can only happen on the closing beat
  a_stall_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> (cnt_q == LAST_CNT))
    else $error("front stalled outside the closing beat");

endmodule

`default_nettype wire

@@ sv/tsm_queue.sv @@
// ----------------------------------------------------------------------------
// tsm_queue: short burst queue
// holds finished bursts between the accumulator and the mapping sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module tsm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tsm_pkg::tsm_burst_t entry_i,
  output logic                space_o,
  output logic                valid_o,
  output tsm_pkg::tsm_burst_t head_o,
  input  logic                pop_i
);
  import tsm_pkg::*;

  tsm_burst_t             slot_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] count_q;

  function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] p);
    return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign space_o = (count_q < QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= next_ptr(rd_ptr_q);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= entry_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < QUEUE_CNT_W'(QUEUE_DEPTH)))
    else $error("burst queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("burst queue underflow");

endmodule

`default_nettype wire

@@ sv/tsm_div.sv @@
// ----------------------------------------------------------------------------
// tsm_div: iterative unsigned divider
// restoring division, two quotient bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tsm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tsm_pkg::DIV_W-1:0]  dividend_i,
  input  logic [tsm_pkg::DIV_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [tsm_pkg::DIV_W-1:0]  quotient_o
);
  import tsm_pkg::*;

  logic [DIV_W-1:0]     rem_q, rem_d, quo_q, quo_d, div_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;

  // two restoring steps per cycle
  always_comb begin
    logic [DIV_W:0]   t;
    logic [DIV_W-1:0] r, q;
    r = rem_q;
    q = quo_q;
    t = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r, q[DIV_W-1]};
      q = {q[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, div_q}) begin
        t    = t - {1'b0, div_q};
        q[0] = 1'b1;
      end
      r = t[DIV_W-1:0];
    end
    rem_d = r;
    quo_d = q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      div_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= '0;
      quo_q  <= dividend_i;
      div_q  <= divisor_i;
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ sv/tsm_back.sv @@
// ----------------------------------------------------------------------------
// tsm_back: mapping sequencer
// trimmed mean, then unless calibrating offset and ratio scaling, rotation and clamping per burst
// ----------------------------------------------------------------------------
`default_nettype none

module tsm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  tsm_pkg::tsm_burst_t head_i,
  output logic                pop_o,
  input  tsm_pkg::tsm_cfg_t   cfg_i,
  tsm_touch_if.source         touch_o
);
  import tsm_pkg::*;

  localparam int unsigned CMP_W = (SUM_W > EXT_W) ? SUM_W : EXT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXT, ST_REST, ST_MUL, ST_CORR, ST_MEAN,
    ST_SETUP, ST_DIV, ST_MAP, ST_EMIT
  } state_e;

  state_e            state_q;
  tsm_burst_t        burst_q;
  logic [EXT_W-1:0]  ext_x_q, ext_y_q;
  logic [SUM_W-1:0]  rest_x_q, rest_y_q, q0_x_q, q0_y_q, rem_x_q, rem_y_q;
  logic [PROD_W-1:0] prod_x_q, prod_y_q;
  logic [DATA_W-1:0] mean_x_q, mean_y_q, res_x_q, res_y_q;
  logic              neg_x_q, neg_y_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_x_q, out_y_q;

  logic                     slot_free, div_start, div_done_x, div_done_y;
  logic [DIV_W-1:0]         quo_x, quo_y, mag_x, mag_y, dsr_x, dsr_y;
  logic signed [POS_W-1:0]  diff_x, diff_y, rx, ry, w, h, tx, ty, lim_x, lim_y;
  logic [DATA_W-1:0]        map_x, map_y;

  function automatic logic [EXT_W-1:0] ext_sum(input tsm_lo_pair_t lo,
                                               input tsm_hi_pair_t hi);
    return EXT_W'(lo[0]) + EXT_W'(lo[1]) + EXT_W'(hi[0]) + EXT_W'(hi[1]);
  endfunction

  function automatic logic [SUM_W-1:0] trim(input logic [SUM_W-1:0] sum,
                                            input logic [EXT_W-1:0] ext);
    logic [CMP_W-1:0] s, e;
    s = CMP_W'(sum);
    e = CMP_W'(ext);
    return (s >= e) ? SUM_W'(s - e) : '0;
  endfunction

  function automatic logic [SUM_W-1:0] q0_of(input logic [PROD_W-1:0] p);
    return SUM_W'(p >> RECIP_SHIFT);
  endfunction

  function automatic logic [DATA_W-1:0] mean_of(input logic [SUM_W-1:0] q0,
                                                input logic [SUM_W-1:0] rem);
    logic [SUM_W-1:0] q;
    q = (rem >= MEAN_DIV_V) ? q0 + 1'b1 : q0;
    return q[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] clamp_to(input logic signed [POS_W-1:0] v,
                                                 input logic signed [POS_W-1:0] lim);
    logic [DATA_W-1:0] r;
    if (v > lim)                  r = lim[DATA_W-1:0];
    else if (v < $signed(POS_W'(0))) r = '0;
    else                          r = v[DATA_W-1:0];
    return r;
  endfunction

  assign pop_o     = (state_q == ST_IDLE) && q_valid_i;
  assign slot_free = !out_valid_q || touch_o.ready;

  // signed offset removal, magnitude goes to the dividers
  assign diff_x = POS_W'(mean_x_q) - POS_W'(cfg_i.offset_x);
  assign diff_y = POS_W'(mean_y_q) - POS_W'(cfg_i.offset_y);

  always_comb begin
    logic signed [POS_W-1:0] ax, ay;
    ax    = diff_x[POS_W-1] ? -diff_x : diff_x;
    ay    = diff_y[POS_W-1] ? -diff_y : diff_y;
    mag_x = ax[DIV_W-1:0];
    mag_y = ay[DIV_W-1:0];
  end

  // a zero ratio divides by one
  assign dsr_x     = (cfg_i.ratio_x == '0) ? DIV_W'(1) : cfg_i.ratio_x;
  assign dsr_y     = (cfg_i.ratio_y == '0) ? DIV_W'(1) : cfg_i.ratio_y;
  assign div_start = (state_q == ST_SETUP) && !cfg_i.calibrate;

  tsm_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_x),
    .divisor_i  (dsr_x),
    .done_o     (div_done_x),
    .quotient_o (quo_x)
  );

  tsm_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_y),
    .divisor_i  (dsr_y),
    .done_o     (div_done_y),
    .quotient_o (quo_y)
  );

  // sign restore, rotation and clamping
  always_comb begin
    logic signed [POS_W-1:0] qx, qy;
    qx = POS_W'(quo_x);
    qy = POS_W'(quo_y);
    rx = neg_x_q ? -qx : qx;
    ry = neg_y_q ? -qy : qy;
    w  = POS_W'(cfg_i.screen_w);
    h  = POS_W'(cfg_i.screen_h);
    unique case (cfg_i.rotation)
      ROT_PORTRAIT_0: begin
        tx = ry;
        ty = w - rx;
      end
      ROT_LANDSCAPE_90: begin
        tx = w - rx;
        ty = h - ry;
      end
      ROT_PORTRAIT_180: begin
        tx = h - ry;
        ty = rx;
      end
      ROT_LANDSCAPE_270: begin
        tx = rx;
        ty = ry;
      end
      default: begin
        tx = rx;
        ty = ry;
      end
    endcase
    lim_x = cfg_i.rotation[0] ? w : h;
    lim_y = cfg_i.rotation[0] ? h : w;
    map_x = clamp_to(tx, lim_x);
    map_y = clamp_to(ty, lim_y);
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
    end else begin
      // load a finished point, or drop the beat once it is taken
      if ((state_q == ST_EMIT) && slot_free) begin
        out_valid_q <= 1'b1;
        out_x_q     <= res_x_q;
        out_y_q     <= res_y_q;
      end else if (touch_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE:  if (q_valid_i) state_q <= ST_EXT;
        ST_EXT:   state_q <= ST_REST;
        ST_REST:  state_q <= ST_MUL;
        ST_MUL:   state_q <= ST_CORR;
        ST_CORR:  state_q <= ST_MEAN;
        ST_MEAN:  state_q <= ST_SETUP;
        ST_SETUP: state_q <= cfg_i.calibrate ? ST_EMIT : ST_DIV;
        ST_DIV:   if (div_done_x && div_done_y) state_q <= ST_MAP;
        ST_MAP:   state_q <= ST_EMIT;
        ST_EMIT:  if (slot_free) state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: burst_q <= head_i;
      ST_EXT: begin
        ext_x_q <= ext_sum(burst_q.lo_x, burst_q.hi_x);
        ext_y_q <= ext_sum(burst_q.lo_y, burst_q.hi_y);
      end
      ST_REST: begin
        rest_x_q <= trim(burst_q.sum_x, ext_x_q);
        rest_y_q <= trim(burst_q.sum_y, ext_y_q);
      end
      ST_MUL: begin
        prod_x_q <= PROD_W'(rest_x_q) * PROD_W'(RECIP_M);
        prod_y_q <= PROD_W'(rest_y_q) * PROD_W'(RECIP_M);
      end
      ST_CORR: begin
        q0_x_q  <= q0_of(prod_x_q);
        q0_y_q  <= q0_of(prod_y_q);
        rem_x_q <= rest_x_q - q0_of(prod_x_q) * MEAN_DIV_V;
        rem_y_q <= rest_y_q - q0_of(prod_y_q) * MEAN_DIV_V;
      end
      ST_MEAN: begin
        mean_x_q <= mean_of(q0_x_q, rem_x_q);
        mean_y_q <= mean_of(q0_y_q, rem_y_q);
      end
      ST_SETUP: begin
        neg_x_q <= diff_x[POS_W-1];
        neg_y_q <= diff_y[POS_W-1];
        res_x_q <= mean_x_q;
        res_y_q <= mean_y_q;
      end
      ST_MAP: begin
        res_x_q <= map_x;
        res_y_q <= map_y;
      end
      default: ;
    endcase
  end

  assign touch_o.valid   = out_valid_q;
  assign touch_o.touch_x = out_x_q;
  assign touch_o.touch_y = out_y_q;

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_x == div_done_y)
    else $error("axis dividers out of step");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && slot_free) |=> out_valid_q)
    else $error("result not loaded into output register");

endmodule

`default_nettype wire

@@ sv/touch_sample_trimmed_mean_mapper.sv @@
// ----------------------------------------------------------------------------
// touch_sample_trimmed_mean_mapper: touch burst filter and screen mapper
// trimmed mean of each good burst, then unless calibrating offset, ratio, rotation and clamping
// ----------------------------------------------------------------------------
//
//   channel    dir   handshake      beat payload
//   sample_i   in    valid/ready    sample_pressure, sample_x, sample_y
//   touch_o    out   valid/ready    touch_x, touch_y
//   cfg        in    cfg_we_i       cfg_idx_i, cfg_wdata_i (no read-back)
//
// the accumulator takes one sample beat per cycle unless stalled; one burst is
// BURST_SAMPLES beats and yields at most one touch beat
// the mapping sequencer takes a new burst only once it has emitted the last,
// mostly waiting on the ratio divider; a two-entry queue decouples it from the front
// the front stalls only on the closing beat of a burst while the queue is full
// reset clears the accumulator, queue count and sequencer state and loads the register defaults; no sweep
//
`default_nettype none

module touch_sample_trimmed_mean_mapper (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tsm_sample_if.sink                     sample_i,
  tsm_touch_if.source                    touch_o,
  input  logic                           cfg_we_i,
  input  logic [tsm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tsm_pkg::DATA_W-1:0]     cfg_wdata_i
);
  import tsm_pkg::*;

  tsm_cfg_t   cfg_q;
  tsm_burst_t entry, head;
  logic       push, space, q_valid, pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (tsm_cfg_idx_e'(cfg_idx_i))
        CFG_CALIBRATE: cfg_q.calibrate <= cfg_wdata_i[0];
        CFG_OFFSET_X:  cfg_q.offset_x  <= cfg_wdata_i;
        CFG_OFFSET_Y:  cfg_q.offset_y  <= cfg_wdata_i;
        CFG_RATIO_X:   cfg_q.ratio_x   <= cfg_wdata_i;
        CFG_RATIO_Y:   cfg_q.ratio_y   <= cfg_wdata_i;
        CFG_SCREEN_W:  cfg_q.screen_w  <= cfg_wdata_i;
        CFG_SCREEN_H:  cfg_q.screen_h  <= cfg_wdata_i;
        CFG_ROTATION:  cfg_q.rotation  <= tsm_rot_e'(cfg_wdata_i[1:0]);
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  // burst accumulator
  tsm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_i),
    .push_o   (push),
    .entry_o  (entry),
    .space_i  (space)
  );

  // finished burst queue
  tsm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .space_o (space),
    .valid_o (q_valid),
    .head_o  (head),
    .pop_i   (pop)
  );

  // mapping sequencer
  tsm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .head_i    (head),
    .pop_o     (pop),
    .cfg_i     (cfg_q),
    .touch_o   (touch_o)
  );

endmodule

`default_nettype wire

@@ dv/touch_sample_trimmed_mean_mapper_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_sample_trimmed_mean_mapper_tb: burst filter and screen mapper test
// drives bursts of touch samples through the valid/ready channels, predicts the
// trimmed mean and the mapped, rotated and clamped point of each good burst,
// and checks every touch beat in order against that prediction
// ----------------------------------------------------------------------------

module touch_sample_trimmed_mean_mapper_tb;
  import tsm_pkg::*;

  localparam int unsigned ACC_W        = 18;
  localparam int unsigned TRIM_DIVISOR = BURST_SAMPLES - 4;
  localparam int unsigned COORD_MAX    = 4095;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_REPORTS  = 40;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
  } touch_point_t;

  // running sums and extremes of the burst in progress
  typedef struct {
    logic [ACC_W-1:0] sum_x;
    logic [ACC_W-1:0] sum_y;
    tsm_lo_pair_t     lo_x;
    tsm_lo_pair_t     lo_y;
    tsm_hi_pair_t     hi_x;
    tsm_hi_pair_t     hi_y;
    int unsigned      count;
    bit               bad;
  } burst_acc_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_wdata_i;

  tsm_sample_if sample_if ();
  tsm_touch_if  touch_if ();

  burst_acc_t   acc;
  tsm_cfg_t     model_cfg;
  touch_point_t pending_touches[$];
  touch_point_t touch_want;
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           rx_hold_left   = 0;
  int           phase_no       = 0;

  touch_sample_trimmed_mean_mapper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_if),
    .touch_o     (touch_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("touch_sample_trimmed_mean_mapper_tb: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic void clear_acc();
    acc.sum_x = '0;
    acc.sum_y = '0;
    acc.lo_x  = {LO_RESET, LO_RESET};
    acc.lo_y  = {LO_RESET, LO_RESET};
    acc.hi_x  = '0;
    acc.hi_y  = '0;
    acc.count = 0;
    acc.bad   = 1'b0;
  endfunction

  // keep the two smallest and two largest values, index 0 most extreme
  function automatic void track_extremes(input logic [DATA_W-1:0] v,
                                         inout tsm_lo_pair_t lo,
                                         inout tsm_hi_pair_t hi);
    if (v < lo[0]) begin
      lo[1] = lo[0];
      lo[0] = LO_W'(v);
    end else if (v < lo[1]) begin
      lo[1] = LO_W'(v);
    end
    if (v > hi[0]) begin
      hi[1] = hi[0];
      hi[0] = v;
    end else if (v > hi[1]) begin
      hi[1] = v;
    end
  endfunction

  function automatic logic [DATA_W-1:0] trimmed_mean(input logic [ACC_W-1:0] sum,
                                                     input tsm_lo_pair_t lo,
                                                     input tsm_hi_pair_t hi);
    int unsigned ext;
    int unsigned rest;
    ext  = lo[0] + lo[1] + hi[0] + hi[1];
    rest = (sum >= ext) ? sum - ext : 0;
    return DATA_W'(rest / TRIM_DIVISOR);
  endfunction

  function automatic int clamp_coord(input int v, input int hi);
    if (v > hi) v = hi;
    if (v < 0) v = 0;
    return v;
  endfunction

  // offset, ratio divide (toward zero), rotation, clamp to the screen
  function automatic touch_point_t map_point(input logic [DATA_W-1:0] mx,
                                             input logic [DATA_W-1:0] my);
    touch_point_t pt;
    int mxi, myi, ox, oy, div_x, div_y, rx, ry, tx, ty, w, h;
    if (model_cfg.calibrate) begin
      pt.x = mx;
      pt.y = my;
      return pt;
    end
    mxi   = mx;
    myi   = my;
    ox    = model_cfg.offset_x;
    oy    = model_cfg.offset_y;
    div_x = model_cfg.ratio_x;
    div_y = model_cfg.ratio_y;
    if (div_x == 0) div_x = 1;
    if (div_y == 0) div_y = 1;
    rx = (mxi - ox) / div_x;
    ry = (myi - oy) / div_y;
    w  = model_cfg.screen_w;
    h  = model_cfg.screen_h;
    case (model_cfg.rotation)
      ROT_PORTRAIT_0: begin
        tx = ry;
        ty = w - rx;
      end
      ROT_LANDSCAPE_90: begin
        tx = w - rx;
        ty = h - ry;
      end
      ROT_PORTRAIT_180: begin
        tx = h - ry;
        ty = rx;
      end
      default: begin
        tx = rx;
        ty = ry;
      end
    endcase
    // landscape keeps the limits, portrait swaps them
    if (model_cfg.rotation[0]) begin
      tx = clamp_coord(tx, w);
      ty = clamp_coord(ty, h);
    end else begin
      tx = clamp_coord(tx, h);
      ty = clamp_coord(ty, w);
    end
    pt.x = DATA_W'(tx);
    pt.y = DATA_W'(ty);
    return pt;
  endfunction

  // fold one accepted sample in; returns 1 when it closes a good burst
  function automatic bit accumulate_sample(input logic [DATA_W-1:0] p,
                                           input logic [DATA_W-1:0] x,
                                           input logic [DATA_W-1:0] y,
                                           output touch_point_t pt);
    logic [DATA_W-1:0] mx, my;
    pt = '0;
    if (p > PRESSURE_MIN) begin
      acc.sum_x = acc.sum_x + x;
      acc.sum_y = acc.sum_y + y;
      track_extremes(x, acc.lo_x, acc.hi_x);
      track_extremes(y, acc.lo_y, acc.hi_y);
    end else begin
      acc.bad = 1'b1;
    end
    acc.count++;
    if (acc.count < BURST_SAMPLES) return 1'b0;
    if (acc.bad) begin
      clear_acc();
      return 1'b0;
    end
    mx = trimmed_mean(acc.sum_x, acc.lo_x, acc.hi_x);
    my = trimmed_mean(acc.sum_y, acc.lo_y, acc.hi_y);
    clear_acc();
    pt = map_point(mx, my);
    return 1'b1;
  endfunction

  // ----------------------------------------------------------- touch receiver

  // ready with random stalls, or held low for a counted stretch
  initial begin
    touch_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        touch_if.ready <= 1'b0;
      end else begin
        touch_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare every touch beat with the oldest pending prediction
  always @(posedge clk_i) begin
    if (rst_ni && touch_if.valid && touch_if.ready) begin
      if (pending_touches.size() == 0) begin
        report_mismatch($sformatf("touch beat (%0d,%0d) with no burst pending",
                                  touch_if.touch_x, touch_if.touch_y));
      end else begin
        touch_want = pending_touches.pop_front();
        if (touch_if.touch_x !== touch_want.x)
          report_mismatch($sformatf("touch_x got %0d want %0d",
                                    touch_if.touch_x, touch_want.x));
        if (touch_if.touch_y !== touch_want.y)
          report_mismatch($sformatf("touch_y got %0d want %0d",
                                    touch_if.touch_y, touch_want.y));
      end
    end
  end

  // ------------------------------------------------------------ drive helpers

  task automatic send_sample(input logic [DATA_W-1:0] p,
                             input logic [DATA_W-1:0] x,
                             input logic [DATA_W-1:0] y);
    touch_point_t pt;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid           <= 1'b1;
    sample_if.sample_pressure <= p;
    sample_if.sample_x        <= x;
    sample_if.sample_y        <= y;
    do @(posedge clk_i); while (!sample_if.ready);
    if (accumulate_sample(p, x, y, pt)) pending_touches.push_back(pt);
  endtask

  function automatic logic [DATA_W-1:0] jitter(input int c, input int spread);
    int v;
    v = c + int'($urandom_range(2 * spread)) - spread;
    return DATA_W'(clamp_coord(v, COORD_MAX));
  endfunction

  // one burst around a random point; some bursts carry weak samples or noise
  task automatic send_burst(input bit force_good);
    int cx, cy, spread, bad_at;
    bit bad, noise;
    logic [DATA_W-1:0] p, x, y;
    bad    = !force_good && ($urandom_range(99) < 15);
    noise  = !force_good && ($urandom_range(19) == 0);
    bad_at = $urandom_range(BURST_SAMPLES - 1);
    cx     = $urandom_range(COORD_MAX);
    cy     = $urandom_range(COORD_MAX);
    spread = ($urandom_range(3) == 0) ? COORD_MAX : $urandom_range(200);
    for (int i = 0; i < BURST_SAMPLES; i++) begin
      p = ($urandom_range(15) == 0) ? PRESSURE_MIN + 1'b1 : DATA_W'($urandom_range(301, 4095));
      if (bad && (i == bad_at || $urandom_range(7) == 0)) p = DATA_W'($urandom_range(300));
      if (noise) p = DATA_W'($urandom_range(COORD_MAX));
      x = ($urandom_range(9) == 0) ? DATA_W'($urandom_range(COORD_MAX)) : jitter(cx, spread);
      y = ($urandom_range(9) == 0) ? DATA_W'($urandom_range(COORD_MAX)) : jitter(cy, spread);
      send_sample(p, x, y);
    end
  endtask

  task automatic send_constant_burst(input logic [DATA_W-1:0] p,
                                     input logic [DATA_W-1:0] x,
                                     input logic [DATA_W-1:0] y);
    for (int i = 0; i < BURST_SAMPLES; i++) send_sample(p, x, y);
  endtask

  // sender pauses until every predicted touch beat has come out
  task automatic wait_results_drained();
    sample_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_touches.size() != 0) @(posedge clk_i);
  endtask

  // a dropped bad burst may still be in flight behind the last touch beat
  task automatic wait_idle();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input tsm_cfg_idx_e idx, input logic [DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // writes every register, then steps the sender idle and receiver stall mode with each new setting
  task automatic program_config(input tsm_cfg_t c);
    write_reg(CFG_CALIBRATE, DATA_W'(c.calibrate));
    write_reg(CFG_OFFSET_X, c.offset_x);
    write_reg(CFG_OFFSET_Y, c.offset_y);
    write_reg(CFG_RATIO_X, c.ratio_x);
    write_reg(CFG_RATIO_Y, c.ratio_y);
    write_reg(CFG_SCREEN_W, c.screen_w);
    write_reg(CFG_SCREEN_H, c.screen_h);
    write_reg(CFG_ROTATION, DATA_W'(c.rotation));
    cfg_we_i  <= 1'b0;
    model_cfg = c;
    case (phase_no % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
      default: begin send_idle_pct = 29; recv_stall_pct = 29; end
    endcase
    phase_no++;
  endtask

  function automatic tsm_cfg_t random_config();
    tsm_cfg_t c;
    c.calibrate = ($urandom_range(3) == 0);
    c.offset_x  = DATA_W'($urandom_range(1) ? $urandom_range(400) : $urandom_range(4095));
    c.offset_y  = DATA_W'($urandom_range(1) ? $urandom_range(400) : $urandom_range(4095));
    c.ratio_x   = DATA_W'($urandom_range(3) ? $urandom_range(1, 16) : $urandom_range(1, 4095));
    c.ratio_y   = DATA_W'($urandom_range(3) ? $urandom_range(1, 16) : $urandom_range(1, 4095));
    c.screen_w  = DATA_W'($urandom_range(3) ? $urandom_range(100, 1023)
                                            : $urandom_range(1, 4095));
    c.screen_h  = DATA_W'($urandom_range(3) ? $urandom_range(100, 1023)
                                            : $urandom_range(1, 4095));
    c.rotation  = tsm_rot_e'($urandom_range(3));
    return c;
  endfunction

  // ------------------------------------------------------------------- tests

  // register defaults straight out of reset, far corner clamps to the screen
  task automatic test_reset_defaults();
    send_burst(1'b1);
    send_constant_burst(DATA_W'(4095), DATA_W'(4095), DATA_W'(4095));
  endtask

  // raw means at the field extremes, and bursts spoiled on their closing or first beat
  task automatic test_extremes();
    tsm_cfg_t c;
    logic [DATA_W-1:0] x;
    wait_idle();
    c = CFG_RESET;
    c.calibrate = 1'b1;
    program_config(c);
    for (int i = 0; i < BURST_SAMPLES; i++) begin
      x = (i < 2) ? '0 : (i < 4) ? DATA_W'(4095) : DATA_W'(i * 257);
      send_sample(i[0] ? DATA_W'(4095) : PRESSURE_MIN + 1'b1, x, ~x);
    end
    for (int i = 0; i < BURST_SAMPLES; i++)
      send_sample((i == BURST_SAMPLES - 1) ? PRESSURE_MIN : DATA_W'(4095),
                  DATA_W'($urandom_range(4095)), DATA_W'($urandom_range(4095)));
    send_constant_burst(PRESSURE_MIN + 1'b1, DATA_W'(4095), '0);
    send_sample('0, '0, '0);
    for (int i = 1; i < BURST_SAMPLES; i++) send_sample(DATA_W'(4095), '0, DATA_W'(4095));
  endtask

  // each orientation with mapping on
  task automatic test_rotations();
    tsm_cfg_t c;
    for (int r = 0; r < 4; r++) begin
      wait_idle();
      c = random_config();
      c.calibrate = 1'b0;
      c.rotation  = tsm_rot_e'(r);
      program_config(c);
      send_burst(1'b1);
    end
  endtask

  // a ratio of zero divides as one
  task automatic test_zero_ratio();
    tsm_cfg_t c;
    wait_idle();
    c = random_config();
    c.calibrate = 1'b0;
    c.ratio_x   = '0;
    c.ratio_y   = '0;
    c.screen_w  = DATA_W'(4095);
    c.screen_h  = DATA_W'(4095);
    program_config(c);
    send_burst(1'b1);
    send_burst(1'b0);
    wait_idle();
    c = random_config();
    c.calibrate = 1'b0;
    c.ratio_x   = '0;
    program_config(c);
    repeat (2) send_burst(1'b0);
  endtask

  // zero screen, full screen, full offset with the largest ratio
  task automatic test_clamp_limits();
    tsm_cfg_t c;
    wait_idle();
    c = random_config();
    c.calibrate = 1'b0;
    c.screen_w  = '0;
    c.screen_h  = '0;
    program_config(c);
    repeat (2) send_burst(1'b1);
    wait_idle();
    c = '{calibrate: 1'b0, offset_x: '0, offset_y: '0, ratio_x: DATA_W'(1),
          ratio_y: DATA_W'(1), screen_w: DATA_W'(4095), screen_h: DATA_W'(4095),
          rotation: ROT_PORTRAIT_180};
    program_config(c);
    repeat (2) send_burst(1'b1);
    wait_idle();
    c = '{calibrate: 1'b0, offset_x: DATA_W'(4095), offset_y: DATA_W'(4095),
          ratio_x: DATA_W'(4095), ratio_y: DATA_W'(4095), screen_w: DATA_W'(1),
          screen_h: DATA_W'(1), rotation: ROT_LANDSCAPE_90};
    program_config(c);
    repeat (2) send_burst(1'b1);
  endtask

  // receiver holds off long enough for the burst queue to fill and stall input
  task automatic test_backpressure();
    wait_idle();
    program_config(random_config());
    send_idle_pct = 0;
    rx_hold_left  = 300;
    repeat (5) send_burst(1'b1);
  endtask

  // random settings, with a full drain in the middle of each setting
  task automatic test_random();
    repeat (2) begin
      wait_idle();
      program_config(random_config());
      send_burst(1'b0);
      wait_results_drained();
      send_burst(1'b0);
    end
  endtask

  initial begin
    rst_ni                    <= 1'b0;
    cfg_we_i                  <= 1'b0;
    cfg_idx_i                 <= CFG_CALIBRATE;
    cfg_wdata_i               <= '0;
    sample_if.valid           <= 1'b0;
    sample_if.sample_pressure <= '0;
    sample_if.sample_x        <= '0;
    sample_if.sample_y        <= '0;
    clear_acc();
    model_cfg = CFG_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_extremes();
    test_rotations();
    test_zero_ratio();
    test_clamp_limits();
    test_backpressure();
    test_random();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("touch_sample_trimmed_mean_mapper_tb: PASS");
    end else begin
      $display("touch_sample_trimmed_mean_mapper_tb: FAIL");
    end
    $finish;
  end

endmodule
